### rtl/led_matrix_row_scanner_top_defines.svh
// Assertion macros shared by the scanner RTL.
`ifndef LED_MATRIX_ROW_SCANNER_TOP_DEFINES_SVH
`define LED_MATRIX_ROW_SCANNER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LMRS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication violated");

// The consequent must hold in the cycle after the antecedent.
`define LMRS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication violated");

// The expression must never be true.
`define LMRS_ASSERT_NEVER(label, clk, rstn, expr) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) \
        else $error("forbidden condition seen");

`endif

### rtl/lmrs_pkg.sv
`default_nettype none

package lmrs_pkg;

    // Frame geometry limits and the frame store size that follows from them.
    localparam int MAX_ROW_BYTES = 32;
    localparam int MAX_ROWS      = 16;
    localparam int STORE_DEPTH   = MAX_ROW_BYTES * MAX_ROWS;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);

    // Field widths.
    localparam int BPR_W       = 6;
    localparam int ROWS_W      = 5;
    localparam int ROW_W       = 4;
    localparam int DATA_W      = 8;
    localparam int X_W         = 8;
    localparam int BIT_SEL_W   = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    // Depth of the command queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Configuration reset values.
    localparam logic [BPR_W-1:0]  BPR_RESET     = BPR_W'(8);
    localparam logic [ROWS_W-1:0] ROWS_RESET    = ROWS_W'(16);
    localparam logic [DATA_W-1:0] MASK_RESET    = 8'hff;
    localparam logic              DISPLAY_RESET = 1'b1;

    // Request opcodes.
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SCAN  = 1'b1;

    // Configuration register indexes.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BYTES_PER_ROW = 2'd0,
        CFG_ROW_COUNT     = 2'd1,
        CFG_DATA_MASK     = 2'd2,
        CFG_DISPLAY_ON    = 2'd3
    } cfg_index_t;

    // One classified command: a pixel bit update or a row scan.
    typedef struct packed {
        logic                  is_scan;
        logic [ADDR_W-1:0]     addr;        // pixel byte, or last byte of the row
        logic [BIT_SEL_W-1:0]  bit_sel;
        logic                  bit_value;
        logic [BPR_W-1:0]      byte_count;  // bytes in the row, 1 to MAX_ROW_BYTES
        logic [ROW_W-1:0]      row_address;
    } lmrs_cmd_t;

    // A command together with its valid flag.
    typedef struct packed {
        logic      valid;
        lmrs_cmd_t cmd;
    } lmrs_slot_t;

    // Status seen by the front.
    typedef struct packed {
        logic queue_full;
        logic clearing;
    } lmrs_front_status_t;

endpackage

`default_nettype wire

### rtl/lmrs_front.sv
`default_nettype none

module lmrs_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic [lmrs_pkg::X_W-1:0]             s_pixel_x,
    input  logic [lmrs_pkg::ROW_W-1:0]           s_pixel_y,
    input  logic                                 s_pixel_value,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lmrs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lmrs_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  lmrs_pkg::lmrs_front_status_t         status,
    output lmrs_pkg::lmrs_slot_t                 push,
    output logic [lmrs_pkg::DATA_W-1:0]          data_mask
);
    import lmrs_pkg::*;

    localparam int PROD_W  = ROW_W + BPR_W;

    logic [BPR_W-1:0]  bpr_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic [DATA_W-1:0] mask_reg;
    logic              display_on_reg;
    logic [ROW_W-1:0]  scan_row_reg;
    logic [ROW_W-1:0]  scan_row_next;

    logic [BPR_W-1:0]  w_eff;
    logic [ROWS_W-1:0] h_eff;
    logic [X_W:0]      x_limit;
    logic              in_frame;
    logic [PROD_W-1:0] wr_prod;
    logic [PROD_W-1:0] wr_idx;
    logic [ROW_W-1:0]  row_sel;
    logic [PROD_W-1:0] scan_prod;
    logic [PROD_W-1:0] scan_last;
    logic [ROWS_W-1:0] row_addr_full;
    logic [ROWS_W-1:0] row_inc;
    logic              accept;
    logic              scan_go;

    // Effective geometry: out-of-range register values are clamped.
    always_comb begin
        if (bpr_reg == '0) begin
            w_eff = BPR_W'(1);
        end else if (bpr_reg > BPR_W'(MAX_ROW_BYTES)) begin
            w_eff = BPR_W'(MAX_ROW_BYTES);
        end else begin
            w_eff = bpr_reg;
        end
        if (rows_reg == '0) begin
            h_eff = ROWS_W'(1);
        end else if (rows_reg > ROWS_W'(MAX_ROWS)) begin
            h_eff = ROWS_W'(MAX_ROWS);
        end else begin
            h_eff = rows_reg;
        end
    end

    // Pixel write address and range check.
    assign x_limit  = {w_eff, 3'b000};
    assign in_frame = ({1'b0, s_pixel_x} < x_limit) && ({1'b0, s_pixel_y} < h_eff);
    assign wr_prod  = PROD_W'(s_pixel_y) * PROD_W'(w_eff);
    assign wr_idx   = wr_prod + PROD_W'(s_pixel_x[X_W-1:BIT_SEL_W]);

    // Scan row selection; a row left stale by a lowered height restarts at zero.
    assign row_sel       = ({1'b0, scan_row_reg} < h_eff) ? scan_row_reg : '0;
    assign scan_prod     = PROD_W'(row_sel) * PROD_W'(w_eff);
    assign scan_last     = scan_prod + PROD_W'(w_eff) - PROD_W'(1);
    assign row_addr_full = h_eff - ROWS_W'(1) - {1'b0, row_sel};
    assign row_inc       = {1'b0, row_sel} + ROWS_W'(1);
    assign scan_row_next = (row_inc == h_eff) ? '0 : row_inc[ROW_W-1:0];

    // Handshake and classification.
    assign s_ready   = !status.queue_full && !status.clearing;
    assign cfg_ready = 1'b1;
    assign accept    = s_valid && s_ready;
    assign scan_go   = accept && (s_op == OP_SCAN) && display_on_reg;
    assign data_mask = mask_reg;

    always_comb begin
        push.cmd.is_scan     = (s_op == OP_SCAN);
        push.cmd.bit_sel     = s_pixel_x[BIT_SEL_W-1:0];
        push.cmd.bit_value   = s_pixel_value;
        push.cmd.byte_count  = w_eff;
        push.cmd.row_address = row_addr_full[ROW_W-1:0];
        push.valid           = 1'b0;
        push.cmd.addr        = wr_idx[ADDR_W-1:0];
        case (s_op)
            OP_WRITE: begin
                push.valid = accept && in_frame;
            end
            OP_SCAN: begin
                push.valid    = scan_go;
                push.cmd.addr = scan_last[ADDR_W-1:0];
            end
            default: begin
                push.valid = 1'b0;
            end
        endcase
    end

    // Configuration registers and the scan row counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpr_reg        <= BPR_RESET;
            rows_reg       <= ROWS_RESET;
            mask_reg       <= MASK_RESET;
            display_on_reg <= DISPLAY_RESET;
            scan_row_reg   <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index_t'(cfg_index))
                    CFG_BYTES_PER_ROW: bpr_reg        <= cfg_data[BPR_W-1:0];
                    CFG_ROW_COUNT:     rows_reg       <= cfg_data[ROWS_W-1:0];
                    CFG_DATA_MASK:     mask_reg       <= cfg_data[DATA_W-1:0];
                    CFG_DISPLAY_ON:    display_on_reg <= cfg_data[0];
                endcase
            end
            if (scan_go) begin
                scan_row_reg <= scan_row_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/lmrs_cmd_queue.sv
`default_nettype none

`include "led_matrix_row_scanner_top_defines.svh"

module lmrs_cmd_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  lmrs_pkg::lmrs_slot_t push,
    input  logic                 pop,
    output lmrs_pkg::lmrs_slot_t head,
    output logic                 full
);
    import lmrs_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    lmrs_cmd_t        entries_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full       = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head.valid = (count_reg != '0);
    assign head.cmd   = entries_reg[rd_ptr_reg];

    // Command storage; no reset needed on the entries.
    always_ff @(posedge aclk) begin
        if (push.valid) begin
            entries_reg[wr_ptr_reg] <= push.cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push.valid) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PTR_W'(1);
            end
            if (push.valid && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push.valid) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // The front must never push into a full queue.
    `LMRS_ASSERT_NEVER(a_no_overflow, aclk, aresetn, push.valid && full && !pop)
    // The fill count never exceeds the depth.
    `LMRS_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH))
    // A lone push grows the queue by one entry.
    `LMRS_ASSERT_NEXT(a_push_grows, aclk, aresetn, push.valid && !pop, count_reg == $past(count_reg) + CNT_W'(1))

endmodule

`default_nettype wire

### rtl/lmrs_back.sv
`default_nettype none

`include "led_matrix_row_scanner_top_defines.svh"

module lmrs_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  lmrs_pkg::lmrs_slot_t          head,
    output logic                          pop,
    output logic                          clearing,
    input  logic [lmrs_pkg::DATA_W-1:0]   data_mask,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [lmrs_pkg::DATA_W-1:0]   m_shift_byte,
    output logic [lmrs_pkg::ROW_W-1:0]    m_row_address,
    output logic                          m_latch
);
    import lmrs_pkg::*;

    // Frame store with a bit-granular write.
    logic [DATA_W-1:0] frame_mem [STORE_DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    logic              clear_active_reg;
    logic [ADDR_W-1:0] clear_addr_reg;

    logic              busy_reg;
    logic [ADDR_W-1:0] cur_addr_reg;
    logic [BPR_W-1:0]  count_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              out_valid_reg;
    logic              out_latch_reg;
    logic [ROW_W-1:0]  out_row_reg;

    logic              slot_free;
    logic              pix_we;
    logic              start_scan;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [BPR_W-1:0]  rd_count;
    logic              rd_last;
    logic [ROW_W-1:0]  rd_row;

    // Issue control: a row byte is read only when the output slot can take it.
    assign slot_free  = !out_valid_reg || m_ready;
    assign pop        = head.valid && !busy_reg && !clear_active_reg
                        && (!head.cmd.is_scan || slot_free);
    assign pix_we     = pop && !head.cmd.is_scan;
    assign start_scan = pop && head.cmd.is_scan;
    assign rd_en      = start_scan || (busy_reg && slot_free);
    assign rd_addr    = busy_reg ? cur_addr_reg : head.cmd.addr;
    assign rd_count   = busy_reg ? count_reg : head.cmd.byte_count;
    assign rd_row     = busy_reg ? row_reg : head.cmd.row_address;
    assign rd_last    = (rd_count == BPR_W'(1));
    assign clearing   = clear_active_reg;

    // Memory port: clearing sweep or pixel update, and a registered read.
    always_ff @(posedge aclk) begin
        if (clear_active_reg) begin
            frame_mem[clear_addr_reg] <= '0;
        end else if (pix_we) begin
            frame_mem[head.cmd.addr][head.cmd.bit_sel] <= head.cmd.bit_value;
        end
        if (rd_en) begin
            rd_data_reg <= frame_mem[rd_addr];
        end
    end

    // Clearing pass over the whole store after reset.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_active_reg <= 1'b1;
            clear_addr_reg   <= '0;
        end else if (clear_active_reg) begin
            if (clear_addr_reg == ADDR_W'(STORE_DEPTH - 1)) begin
                clear_active_reg <= 1'b0;
            end
            clear_addr_reg <= clear_addr_reg + ADDR_W'(1);
        end
    end

    // Row walk from the last byte down to the first, one byte per cycle while the output slot is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (rd_en) begin
                out_valid_reg <= 1'b1;
                out_latch_reg <= rd_last;
                out_row_reg   <= rd_last ? rd_row : '0;
                busy_reg      <= !rd_last;
                count_reg     <= rd_count - BPR_W'(1);
                cur_addr_reg  <= rd_addr - ADDR_W'(1);
                row_reg       <= rd_row;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_shift_byte  = rd_data_reg ^ data_mask;
    assign m_row_address = out_row_reg;
    assign m_latch       = out_latch_reg;

    // No command leaves the queue while the store is being cleared.
    `LMRS_ASSERT_NEVER(a_no_pop_clearing, aclk, aresetn, clear_active_reg && pop)
    // A row in progress always has bytes left.
    `LMRS_ASSERT_IMPL(a_busy_count, aclk, aresetn, busy_reg, count_reg != '0)
    // The latch byte closes the row walk.
    `LMRS_ASSERT_IMPL(a_latch_done, aclk, aresetn, out_valid_reg && out_latch_reg, !busy_reg)
    // Starting a scan always presents a byte next cycle.
    `LMRS_ASSERT_NEXT(a_scan_shows, aclk, aresetn, start_scan, out_valid_reg)

endmodule

`default_nettype wire

### rtl/led_matrix_row_scanner_top.sv
// Pixel write: queued, then applied to the frame store in the back end; no result.
// Row scan: the command passes through the queue to the back end, then one byte
// per cycle while m_ready allows (set by the single frame store read port).
// Reset: synchronous active-low; config returns to defaults, scan row to zero,
// and a clearing pass over all 512 frame store entries holds s_ready low.
`default_nettype none

module led_matrix_row_scanner_top (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_op,
    input  logic [lmrs_pkg::X_W-1:0]             s_pixel_x,
    input  logic [lmrs_pkg::ROW_W-1:0]           s_pixel_y,
    input  logic                                 s_pixel_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [lmrs_pkg::DATA_W-1:0]          m_shift_byte,
    output logic [lmrs_pkg::ROW_W-1:0]           m_row_address,
    output logic                                 m_latch,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lmrs_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [lmrs_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import lmrs_pkg::*;

    lmrs_slot_t         push;
    lmrs_slot_t         head;
    lmrs_front_status_t front_status;
    logic               pop;
    logic               queue_full;
    logic               clearing;
    logic [DATA_W-1:0]  data_mask;

    assign front_status.queue_full = queue_full;
    assign front_status.clearing   = clearing;

    // Front: request intake, configuration, classification.
    lmrs_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_pixel_x     (s_pixel_x),
        .s_pixel_y     (s_pixel_y),
        .s_pixel_value (s_pixel_value),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .status        (front_status),
        .push          (push),
        .data_mask     (data_mask)
    );

    // Command queue decoupling front and back.
    lmrs_cmd_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .head    (head),
        .full    (queue_full)
    );

    // Back: frame store, row walk and output register.
    lmrs_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (head),
        .pop           (pop),
        .clearing      (clearing),
        .data_mask     (data_mask),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_shift_byte  (m_shift_byte),
        .m_row_address (m_row_address),
        .m_latch       (m_latch)
    );

endmodule

`default_nettype wire

### tb/tb_top.sv
`default_nettype none

module tb_top;
    import lmrs_pkg::*;

    // Cycles allowed for the block to drain before a register write and at the end.
    localparam int unsigned SETTLE_CYCLES = 64;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int unsigned SEGMENTS      = 4;
    localparam int unsigned SEGMENT_ITEMS = 40;
    localparam int unsigned PRINT_CAP     = 40;

    typedef enum {STEP_REQUEST, STEP_REGISTER, STEP_SETTLE, STEP_PACE} step_kind_t;

    // One entry of the driver's work list.
    typedef struct {
        step_kind_t              kind;
        logic                    op;
        logic [X_W-1:0]          x;
        logic [ROW_W-1:0]        y;
        logic                    value;
        cfg_index_t              index;
        logic [CFG_DATA_W-1:0]   data;
        int unsigned             send_pct;
        int unsigned             recv_pct;
    } scan_step_t;

    // One byte that the block shifts out.
    typedef struct packed {
        logic [DATA_W-1:0] shift_byte;
        logic [ROW_W-1:0]  row_address;
        logic              latch;
    } row_byte_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic                    s_op = 1'b0;
    logic [X_W-1:0]          s_pixel_x = '0;
    logic [ROW_W-1:0]        s_pixel_y = '0;
    logic                    s_pixel_value = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    logic [DATA_W-1:0]       m_shift_byte;
    logic [ROW_W-1:0]        m_row_address;
    logic                    m_latch;
    logic                    cfg_valid = 1'b0;
    logic                    cfg_ready;
    logic [CFG_INDEX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_data = '0;

    // Handshakes seen at the last rising edge, for the driver.
    logic s_fire = 1'b0;
    logic cfg_fire = 1'b0;

    scan_step_t  pending_steps[$];
    row_byte_t   expected_bytes[$];
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned settle_count = 0;
    int unsigned cycle_count = 0;

    // Shadow of the frame, the scan position and the registers.
    logic [DATA_W-1:0] frame_bytes [STORE_DEPTH];
    logic [ROW_W-1:0]  scan_row_q;
    logic [BPR_W-1:0]  width_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic [DATA_W-1:0] mask_reg;
    logic              display_reg;

    int unsigned mismatches = 0;
    int unsigned writes_seen = 0;
    int unsigned scans_seen = 0;
    int unsigned dark_scans = 0;
    int unsigned registers_seen = 0;
    int unsigned bytes_checked = 0;
    int unsigned latches_checked = 0;

    led_matrix_row_scanner_top uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_op          (s_op),
        .s_pixel_x     (s_pixel_x),
        .s_pixel_y     (s_pixel_y),
        .s_pixel_value (s_pixel_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_shift_byte  (m_shift_byte),
        .m_row_address (m_row_address),
        .m_latch       (m_latch),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // Row width in bytes after clamping the register to the legal range.
    function automatic int unsigned row_bytes_of(logic [BPR_W-1:0] raw);
        int unsigned w;
        w = raw;
        if (w < 1) w = 1;
        if (w > MAX_ROW_BYTES) w = MAX_ROW_BYTES;
        return w;
    endfunction

    // Number of scanned rows after clamping the register to the legal range.
    function automatic int unsigned rows_of(logic [ROWS_W-1:0] raw);
        int unsigned h;
        h = raw;
        if (h < 1) h = 1;
        if (h > MAX_ROWS) h = MAX_ROWS;
        return h;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        if (mismatches < PRINT_CAP)
            $display("ERROR at cycle %0d: %s: got 0x%0h, expected 0x%0h",
                     cycle_count, what, got, want);
        mismatches++;
    endtask

    // Update the frame for a pixel write, or queue the row bytes a scan shifts out.
    task automatic predict_request(input logic op, input logic [X_W-1:0] x,
                                   input logic [ROW_W-1:0] y, input logic value);
        int unsigned w;
        int unsigned h;
        int unsigned row;
        int unsigned idx;
        int unsigned k;
        row_byte_t   rb;
        w = row_bytes_of(width_reg);
        h = rows_of(rows_reg);
        if (op == OP_WRITE) begin
            writes_seen++;
            if (int'(x) < w * 8 && int'(y) < h) begin
                idx = y * w + x / 8;
                frame_bytes[idx][x[BIT_SEL_W-1:0]] = value;
            end
        end else begin
            scans_seen++;
            if (!display_reg) begin
                dark_scans++;
            end else begin
                row = scan_row_q;
                // A row left over from a taller setting restarts at the top.
                if (row >= h) row = 0;
                for (k = w; k > 0; k--) begin
                    rb.shift_byte  = frame_bytes[row * w + k - 1] ^ mask_reg;
                    rb.latch       = (k == 1);
                    rb.row_address = (k == 1) ? ROW_W'(h - 1 - row) : '0;
                    expected_bytes.push_back(rb);
                end
                scan_row_q = ROW_W'((row + 1) % h);
            end
        end
    endtask

    // Monitor: track register writes and requests, and check every result byte.
    always @(posedge aclk) begin : monitor
        row_byte_t want;
        int i;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Simulation FAILED");
            $finish;
        end else begin
            s_fire   <= aresetn && s_valid && s_ready;
            cfg_fire <= aresetn && cfg_valid && cfg_ready;
            if (!aresetn) begin
                for (i = 0; i < STORE_DEPTH; i++) frame_bytes[i] = '0;
                scan_row_q  = '0;
                width_reg   = BPR_RESET;
                rows_reg    = ROWS_RESET;
                mask_reg    = MASK_RESET;
                display_reg = DISPLAY_RESET;
            end else begin
                if (m_valid && m_ready) begin
                    if (expected_bytes.size() == 0) begin
                        report_mismatch("row byte with nothing pending", m_shift_byte, 0);
                    end else begin
                        want = expected_bytes.pop_front();
                        if (m_shift_byte !== want.shift_byte)
                            report_mismatch("shift_byte", m_shift_byte, want.shift_byte);
                        if (m_row_address !== want.row_address)
                            report_mismatch("row_address", m_row_address, want.row_address);
                        if (m_latch !== want.latch)
                            report_mismatch("latch", m_latch, want.latch);
                        bytes_checked++;
                        if (want.latch) latches_checked++;
                    end
                end
                if (cfg_valid && cfg_ready) begin
                    registers_seen++;
                    case (cfg_index_t'(cfg_index))
                        CFG_BYTES_PER_ROW: width_reg   = cfg_data[BPR_W-1:0];
                        CFG_ROW_COUNT:     rows_reg    = cfg_data[ROWS_W-1:0];
                        CFG_DATA_MASK:     mask_reg    = cfg_data[DATA_W-1:0];
                        CFG_DISPLAY_ON:    display_reg = cfg_data[0];
                        default: ;
                    endcase
                end
                if (s_valid && s_ready)
                    predict_request(s_op, s_pixel_x, s_pixel_y, s_pixel_value);
            end
        end
    end

    // Driver: works through the step list one entry at a time on the falling edge.
    always @(negedge aclk) begin : driver
        scan_step_t st;
        logic req_live;
        logic reg_live;
        req_live = s_valid && !s_fire;
        reg_live = cfg_valid && !cfg_fire;
        m_ready <= ($urandom_range(99) >= recv_stall_pct);
        if (aresetn && !req_live && !reg_live && pending_steps.size() != 0) begin
            st = pending_steps[0];
            case (st.kind)
                STEP_REQUEST: begin
                    if ($urandom_range(99) >= send_idle_pct) begin
                        s_op          <= st.op;
                        s_pixel_x     <= st.x;
                        s_pixel_y     <= st.y;
                        s_pixel_value <= st.value;
                        req_live = 1'b1;
                        void'(pending_steps.pop_front());
                    end
                end
                STEP_REGISTER: begin
                    cfg_index <= st.index;
                    cfg_data  <= st.data;
                    reg_live = 1'b1;
                    void'(pending_steps.pop_front());
                end
                STEP_SETTLE: begin
                    // Hold off until every row byte is back and the block has gone quiet.
                    if (expected_bytes.size() != 0) begin
                        settle_count = 0;
                    end else if (settle_count < SETTLE_CYCLES) begin
                        settle_count++;
                    end else begin
                        settle_count = 0;
                        void'(pending_steps.pop_front());
                    end
                end
                STEP_PACE: begin
                    send_idle_pct  = st.send_pct;
                    recv_stall_pct = st.recv_pct;
                    void'(pending_steps.pop_front());
                end
                default: void'(pending_steps.pop_front());
            endcase
        end
        s_valid   <= req_live;
        cfg_valid <= reg_live;
    end

    task automatic add_request(logic op, int unsigned x, int unsigned y, logic value);
        scan_step_t st;
        st = '{kind: STEP_REQUEST, index: CFG_BYTES_PER_ROW, default: 0};
        st.kind  = STEP_REQUEST;
        st.op    = op;
        st.x     = X_W'(x);
        st.y     = ROW_W'(y);
        st.value = value;
        pending_steps.push_back(st);
    endtask

    // A register write always waits for the block to drain first.
    task automatic add_register(cfg_index_t index, logic [CFG_DATA_W-1:0] data);
        scan_step_t st;
        st = '{kind: STEP_REQUEST, index: CFG_BYTES_PER_ROW, default: 0};
        st.kind = STEP_SETTLE;
        pending_steps.push_back(st);
        st.kind  = STEP_REGISTER;
        st.index = index;
        st.data  = data;
        pending_steps.push_back(st);
    endtask

    task automatic add_pace(int unsigned send_pct, int unsigned recv_pct);
        scan_step_t st;
        st = '{kind: STEP_REQUEST, index: CFG_BYTES_PER_ROW, default: 0};
        st.kind     = STEP_PACE;
        st.send_pct = send_pct;
        st.recv_pct = recv_pct;
        pending_steps.push_back(st);
    endtask

    // Stimulus: a directed opening, then three pacing phases of random segments.
    initial begin : stimulus
        int unsigned phase;
        int unsigned seg;
        int unsigned n;
        int unsigned pick;
        int unsigned plan_w;
        int unsigned plan_h;
        logic [BPR_W-1:0]      raw_w;
        logic [ROWS_W-1:0]     raw_h;
        logic [DATA_W-1:0]     mask;
        logic [31:0]           pad;

        // Directed opening at the reset geometry of 8 bytes by 16 rows.
        add_pace(14, 80);
        add_request(OP_WRITE, 0, 0, 1'b1);
        add_request(OP_WRITE, 63, 15, 1'b1);
        add_request(OP_WRITE, 64, 3, 1'b1);
        add_request(OP_WRITE, 255, 15, 1'b1);
        add_request(OP_WRITE, 9, 0, 1'b1);
        add_request(OP_WRITE, 9, 0, 1'b0);
        add_request(OP_WRITE, 15, 0, 1'b1);
        add_request(OP_SCAN, 0, 0, 1'b0);
        add_request(OP_SCAN, 0, 0, 1'b0);
        // Lowering the height leaves the scan row past the end.
        add_register(CFG_ROW_COUNT, 8'd2);
        add_register(CFG_DATA_MASK, 8'h00);
        add_request(OP_SCAN, 0, 0, 1'b0);
        add_request(OP_SCAN, 0, 0, 1'b0);
        add_request(OP_SCAN, 0, 0, 1'b0);
        // Zero width and zero height both clamp to one.
        add_register(CFG_BYTES_PER_ROW, 8'd0);
        add_register(CFG_ROW_COUNT, 8'd0);
        add_request(OP_WRITE, 7, 0, 1'b1);
        add_request(OP_WRITE, 8, 0, 1'b1);
        add_request(OP_WRITE, 0, 1, 1'b1);
        add_request(OP_SCAN, 0, 0, 1'b0);
        // Oversized width and height clamp to the maximum frame.
        add_register(CFG_BYTES_PER_ROW, 8'd63);
        add_register(CFG_ROW_COUNT, 8'd31);
        add_register(CFG_DATA_MASK, 8'ha5);
        add_request(OP_WRITE, 255, 15, 1'b1);
        add_request(OP_WRITE, 255, 0, 1'b1);
        add_request(OP_WRITE, 128, 0, 1'b1);
        add_request(OP_SCAN, 0, 0, 1'b0);
        // With the display dark, scans are dropped but writes still land.
        add_register(CFG_DISPLAY_ON, 8'd0);
        add_request(OP_SCAN, 0, 0, 1'b0);
        add_request(OP_WRITE, 3, 1, 1'b1);
        add_register(CFG_DISPLAY_ON, 8'd1);
        add_register(CFG_DATA_MASK, 8'hff);
        add_request(OP_SCAN, 0, 0, 1'b0);

        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: add_pace(14, 80);
                1: add_pace(80, 14);
                default: add_pace(0, 0);
            endcase
            for (seg = 0; seg < SEGMENTS; seg++) begin
                // Pick a geometry, mostly narrow, now and then out of range.
                pick = $urandom_range(9);
                case (pick)
                    0: raw_w = '0;
                    1: raw_w = BPR_W'($urandom_range(63, 32));
                    2: raw_w = BPR_W'($urandom_range(32, 9));
                    default: raw_w = BPR_W'($urandom_range(8, 1));
                endcase
                pick = $urandom_range(9);
                case (pick)
                    0: raw_h = '0;
                    1: raw_h = ROWS_W'($urandom_range(31, 16));
                    default: raw_h = ROWS_W'($urandom_range(16, 1));
                endcase
                pick = $urandom_range(9);
                case (pick)
                    0: mask = 8'h00;
                    1: mask = 8'hff;
                    default: mask = DATA_W'($urandom);
                endcase
                pad = $urandom;
                add_register(CFG_BYTES_PER_ROW, {pad[1:0], raw_w});
                add_register(CFG_ROW_COUNT, {pad[4:2], raw_h});
                add_register(CFG_DATA_MASK, mask);
                add_register(CFG_DISPLAY_ON, {pad[11:5], ($urandom_range(99) < 85)});
                plan_w = row_bytes_of(raw_w);
                plan_h = rows_of(raw_h);
                for (n = 0; n < SEGMENT_ITEMS; n++) begin
                    pick = $urandom_range(99);
                    if (pick < 35)
                        add_request(OP_SCAN, $urandom_range(255), $urandom_range(15),
                                    1'($urandom));
                    else if (pick < 90)
                        add_request(OP_WRITE, $urandom_range(plan_w * 8 - 1),
                                    $urandom_range(plan_h - 1), 1'($urandom));
                    else
                        add_request(OP_WRITE, $urandom_range(255), $urandom_range(15),
                                    1'($urandom));
                end
            end
        end

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Wait for the last request, then for the last row byte, then let it settle.
        while (pending_steps.size() != 0 || s_valid || cfg_valid) @(posedge aclk);
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Ran %0d pixel writes and %0d row scans (%0d while dark), %0d register writes.",
                 writes_seen, scans_seen, dark_scans, registers_seen);
        $display("Checked %0d row bytes, %0d of them row ends with latch, %0d mismatches.",
                 bytes_checked, latches_checked, mismatches);
        if (mismatches == 0 && expected_bytes.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
